// ===== sv/uart_baud_divisor_search_unit_defines.svh =====
// Assertion macros for the baud divisor search unit
`ifndef UART_BAUD_DIVISOR_SEARCH_UNIT_DEFINES_SVH
`define UART_BAUD_DIVISOR_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define UBDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UBDS_ASSERT_NOW(lbl, ante, cons, msg)
`define UBDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ubds_pkg.sv =====
// Shared types and constants for the baud divisor search unit
package ubds_pkg;
  localparam int unsigned OSR_MIN   = 4;
  localparam int unsigned OSR_MAX   = 32;
  localparam int unsigned OSR_W     = $clog2(OSR_MAX + 1);
  localparam int unsigned BAUD_W    = 23;
  localparam int unsigned CLK_W     = 32;
  localparam int unsigned SBR_W     = 13;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned DCNT_W    = $clog2(CLK_W + 1);
  localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd24000000;
  localparam logic [CLK_W-1:0] SBR_MASK    = 32'h0000_1FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_EVAL,
    ST_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    PH_FLOOR,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CLK_W-1:0] quo;
  } div_stat_t;
endpackage

// ===== sv/ubds_front.sv =====
// Front end: clock register and two-entry request queue
module ubds_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ubds_pkg::CLK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ubds_pkg::BAUD_W-1:0]   req_baud,
  input  logic                          pop,
  output logic                          q_valid,
  output logic [ubds_pkg::BAUD_W-1:0]   q_baud,
  output logic [ubds_pkg::CLK_W-1:0]    module_clock
);
  import ubds_pkg::*;

  logic [BAUD_W-1:0] slot [2];
  logic              rd_ptr;
  logic              wr_ptr;
  logic [1:0]        count;
  logic              push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_baud   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      module_clock <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      module_clock <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req_baud;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && q_valid);
    end
  end
endmodule

// ===== sv/ubds_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
module ubds_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ubds_pkg::CLK_W-1:0]  dividend,
  input  logic [ubds_pkg::CLK_W-1:0]  divisor_in,
  output ubds_pkg::div_stat_t         stat
);
  import ubds_pkg::*;

  logic [CLK_W:0]    rem;
  logic [CLK_W-1:0]  aq;
  logic [CLK_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [CLK_W:0]    sh;
  logic              fits;

  assign sh   = {rem[CLK_W-1:0], aq[CLK_W-1]};
  assign fits = (sh >= {1'b0, dvs});

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quo  = aq;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      aq  <= dividend;
      dvs <= divisor_in;
    end else if (busy) begin
      rem <= fits ? (sh - {1'b0, dvs}) : sh;
      aq  <= {aq[CLK_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(CLK_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/ubds_back.sv =====
// Back end: ratio sweep sequencer, error compare and result register
`include "uart_baud_divisor_search_unit_defines.svh"
module ubds_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [ubds_pkg::BAUD_W-1:0]  q_baud,
  input  logic [ubds_pkg::CLK_W-1:0]   module_clock,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ubds_pkg::CODE_W-1:0]  osr_code,
  output logic [ubds_pkg::SBR_W-1:0]   divisor,
  output logic                         divisor_overflow,
  output logic                         both_edge,
  output logic [ubds_pkg::BAUD_W-1:0]  rate_error
);
  import ubds_pkg::*;

  back_state_t        state, state_next;
  phase_t             phase;
  logic [OSR_W-1:0]   ratio;
  logic [CLK_W-1:0]   baud;
  logic [CLK_W-1:0]   dreg;
  logic [CLK_W-1:0]   sbr;
  logic [CLK_W-1:0]   qa;
  logic [CLK_W-1:0]   qb;
  logic [CLK_W-1:0]   best_err;
  logic [CLK_W-1:0]   best_sbr;
  logic [OSR_W-1:0]   best_osr;
  logic [CLK_W-1:0]   mul_op;
  logic [CLK_W+OSR_W-1:0] prod;
  logic [CLK_W-1:0]   err_dn;
  logic [CLK_W-1:0]   err_up;
  logic [CLK_W-1:0]   err;
  logic [CLK_W-1:0]   cand_sbr;
  logic               div_start;
  logic               load_out;
  div_stat_t          dstat;
  logic [OSR_W-1:0]   osr_m1;

  ubds_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend   (module_clock),
    .divisor_in (dreg),
    .stat       (dstat)
  );

  always_comb begin
    case (phase)
      PH_FLOOR: mul_op = baud;
      PH_LOW:   mul_op = sbr;
      PH_HIGH:  mul_op = sbr + 1'b1;
      default:  mul_op = sbr;
    endcase
  end

  assign prod     = mul_op * ratio;
  assign err_dn   = qa - baud;
  assign err_up   = baud - qb;
  assign err      = (err_dn > err_up) ? err_up : err_dn;
  assign cand_sbr = (err_dn > err_up) ? (sbr + 1'b1) : sbr;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (dstat.done) begin
          state_next = (phase == PH_HIGH) ? ST_EVAL : ST_MUL;
        end
      end
      ST_EVAL: begin
        state_next = (ratio == OSR_W'(OSR_MAX)) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLOOR;
      ratio <= OSR_W'(OSR_MIN);
    end else begin
      case (state)
        ST_IDLE: begin
          phase <= PH_FLOOR;
          ratio <= OSR_W'(OSR_MIN);
        end
        ST_DWAIT: begin
          if (dstat.done) begin
            case (phase)
              PH_FLOOR: phase <= PH_LOW;
              PH_LOW:   phase <= PH_HIGH;
              default:  phase <= PH_FLOOR;
            endcase
          end
        end
        ST_EVAL: ratio <= ratio + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        baud     <= {{(CLK_W-BAUD_W){1'b0}}, q_baud};
        best_err <= {{(CLK_W-BAUD_W){1'b0}}, q_baud};
        best_sbr <= '0;
        best_osr <= '0;
      end
      ST_MUL: dreg <= prod[CLK_W-1:0];
      ST_DWAIT: begin
        if (dstat.done) begin
          case (phase)
            PH_FLOOR: sbr <= (dstat.quo == '0) ? CLK_W'(1) : dstat.quo;
            PH_LOW:   qa  <= dstat.quo;
            default:  qb  <= dstat.quo;
          endcase
        end
      end
      ST_EVAL: begin
        if (err <= best_err) begin
          best_err <= err;
          best_sbr <= cand_sbr;
          best_osr <= ratio;
        end
      end
      default: ;
    endcase
  end

  assign osr_m1 = best_osr - 1'b1;

  always_ff @(posedge clk) begin
    if (load_out) begin
      osr_code         <= osr_m1[CODE_W-1:0];
      divisor          <= best_sbr[SBR_W-1:0];
      divisor_overflow <= (best_sbr > SBR_MASK);
      both_edge        <= (best_osr >= OSR_W'(4)) && (best_osr <= OSR_W'(7));
      rate_error       <= best_err[BAUD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `UBDS_ASSERT_NOW(a_div_start_idle, div_start, !dstat.busy, "divider restarted while busy")
  `UBDS_ASSERT_NOW(a_ratio_range, state != ST_IDLE, (ratio >= OSR_W'(OSR_MIN)) && (ratio <= OSR_W'(OSR_MAX + 1)), "ratio out of range")
  `UBDS_ASSERT_NOW(a_done_in_wait, dstat.done, state == ST_DWAIT, "divider result outside wait")
  `UBDS_ASSERT_NEXT(a_pop_starts, pop, state == ST_MUL, "pop did not start a sweep")
endmodule

// ===== sv/uart_baud_divisor_search_unit.sv =====
// Top level of the UART baud divisor search unit
// Each requested baud rate is swept over oversampling ratios 4 to 32; every ratio needs
// three 32-bit divisions of the module clock, done by one shared bit-serial divider at
// one quotient bit per cycle. A two-entry queue takes further requests while a sweep
// runs, and a finished result waits in the output register while the next sweep
// proceeds. module_clock resets to 24 MHz; write it only while the unit is idle.
module uart_baud_divisor_search_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ubds_pkg::CLK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ubds_pkg::BAUD_W-1:0]   req_baud,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ubds_pkg::CODE_W-1:0]   osr_code,
  output logic [ubds_pkg::SBR_W-1:0]    divisor,
  output logic                          divisor_overflow,
  output logic                          both_edge,
  output logic [ubds_pkg::BAUD_W-1:0]   rate_error
);
  import ubds_pkg::*;

  logic              pop;
  logic              q_valid;
  logic [BAUD_W-1:0] q_baud;
  logic [CLK_W-1:0]  module_clock;

  ubds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_baud     (req_baud),
    .pop          (pop),
    .q_valid      (q_valid),
    .q_baud       (q_baud),
    .module_clock (module_clock)
  );

  ubds_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_baud           (q_baud),
    .module_clock     (module_clock),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .osr_code         (osr_code),
    .divisor          (divisor),
    .divisor_overflow (divisor_overflow),
    .both_edge        (both_edge),
    .rate_error       (rate_error)
  );
endmodule

// ===== test/uart_baud_divisor_search_unit_test.sv =====
// Self-checking testbench for the UART baud divisor search unit
`timescale 1ns / 100ps

module uart_baud_divisor_search_unit_test;
  import ubds_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] osr_code;
    logic [SBR_W-1:0]  divisor;
    logic              divisor_overflow;
    logic              both_edge;
    logic [BAUD_W-1:0] rate_error;
  } baud_choice_t;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 12000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CLK_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BAUD_W-1:0] req_baud = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] osr_code;
  logic [SBR_W-1:0]  divisor;
  logic              divisor_overflow;
  logic              both_edge;
  logic [BAUD_W-1:0] rate_error;

  logic [BAUD_W-1:0] pending_bauds[$];
  baud_choice_t      expected_choices[$];
  logic [CLK_W-1:0]  module_clock = CLOCK_RESET;
  bit                quiet = 1'b0;
  int                mismatches = 0;
  int                bauds_taken = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  int                stuck_cycles = 0;

  uart_baud_divisor_search_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_baud(req_baud),
    .out_valid(out_valid), .out_ready(out_ready),
    .osr_code(osr_code), .divisor(divisor), .divisor_overflow(divisor_overflow),
    .both_edge(both_edge), .rate_error(rate_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] udiv32(logic [31:0] a, logic [31:0] b);
    return (b == 32'd0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  function automatic baud_choice_t search_divisor(logic [BAUD_W-1:0] baud,
                                                  logic [CLK_W-1:0] fclk);
    logic [31:0]  b;
    logic [31:0]  best_err;
    logic [31:0]  best_osr;
    logic [31:0]  best_sbr;
    logic [31:0]  sbr;
    logic [31:0]  err;
    logic [31:0]  err_up;
    baud_choice_t c;
    b = 32'(baud);
    best_err = b;
    best_osr = 0;
    best_sbr = 0;
    for (int unsigned r = OSR_MIN; r <= OSR_MAX; r++) begin
      sbr = udiv32(fclk, b * 32'(r));
      if (sbr == 32'd0) sbr = 32'd1;
      err = udiv32(fclk, 32'(r) * sbr) - b;
      err_up = b - udiv32(fclk, 32'(r) * (sbr + 32'd1));
      if (err > err_up) begin
        err = err_up;
        sbr = sbr + 32'd1;
      end
      if (err <= best_err) begin
        best_err = err;
        best_osr = 32'(r);
        best_sbr = sbr;
      end
    end
    c.osr_code = CODE_W'(best_osr - 32'd1);
    c.divisor = best_sbr[SBR_W-1:0];
    c.divisor_overflow = best_sbr > SBR_MASK;
    c.both_edge = best_osr > 32'd3 && best_osr < 32'd8;
    c.rate_error = best_err[BAUD_W-1:0];
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_choices.push_back(search_divisor(req_baud, module_clock));
        bauds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bauds.size() > 0 && (quiet || $urandom_range(0, 3) != 0)) begin
          in_valid <= 1'b1;
          req_baud <= pending_bauds.pop_front();
        end else begin
          if (pending_bauds.size() > 0) send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    baud_choice_t want;
    baud_choice_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{osr_code, divisor, divisor_overflow, both_edge, rate_error};
        if (expected_choices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %p", got);
        end else begin
          want = expected_choices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (!hold_done && bauds_taken >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_bauds.size() > 0 || in_valid || expected_choices.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_module_clock(logic [CLK_W-1:0] hz);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    module_clock = hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [BAUD_W-1:0] random_baud();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return BAUD_W'($urandom_range(1200, 8000000));
    if (pick < 8) return BAUD_W'($urandom_range(1200, 230400));
    return BAUD_W'($urandom);
  endfunction

  initial begin
    logic [CLK_W-1:0] clocks[6];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats at the reset clock
    pending_bauds = '{23'd0, 23'd1, 23'd2, 23'd1200, 23'd9600, 23'd115200,
                      23'd3000000, 23'd6000000, 23'd8000000, 23'h7FFFFF,
                      23'h555555, 23'h2AAAAA, 23'd750000, 23'd187500, 23'd4};
    drain_and_settle();

    clocks = '{32'd1000000, 32'hFFFF_FFFF, 32'd48000000, $urandom_range(1000000, 32'hFFFF_FFFF),
               32'd80000000, CLOCK_RESET};
    foreach (clocks[p]) begin
      set_module_clock(clocks[p]);
      if (p == 1) pending_bauds = '{23'd1200, 23'd0, 23'h7FFFFF, 23'd1};
      for (int i = 0; i < 140; i++) pending_bauds.push_back(random_baud());
      if (p == 5) begin
        do @(posedge clk); while (pending_bauds.size() > 40);
        quiet = 1'b1;
      end
      drain_and_settle();
    end

    if (mismatches == 0 && expected_choices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
